>>> rtl/act_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated tilt package
// Shared constants, codes, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package act_pkg;

  localparam int MAX_CAL_SAMPLES   = 1024;
  localparam int CNT_W             = $clog2(MAX_CAL_SAMPLES + 1);
  localparam int CORDIC_ITERATIONS = 16;
  localparam int SQRT_STEPS        = 18;
  localparam int DIV_STEPS         = 28;
  localparam int MUL_STEPS         = 7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDEF   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_ACK     = 2'd3;

  typedef enum logic [1:0] {
    KIND_MEASURE   = 2'd0,
    KIND_CAL_START = 2'd1,
    KIND_CAL_ADD   = 2'd2,
    KIND_CAL_END   = 2'd3
  } act_kind_e;

  typedef enum logic [2:0] {
    REG_GAIN_X   = 3'd0,
    REG_GAIN_Y   = 3'd1,
    REG_GAIN_Z   = 3'd2,
    REG_GRAVITY  = 3'd3,
    REG_MIN_NORM = 3'd4
  } act_reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_CAL, S_MUL, S_CHECK, S_SQRT, S_LOAD_P, S_CORD_P,
    S_LOAD_R, S_CORD_R, S_FIN_R, S_DIV_INIT, S_DIV, S_DIV_END, S_DONE
  } act_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CAL, OP_MUL, OP_CHECK, OP_SQRT_STEP, OP_LOAD_P,
    OP_CORD_STEP, OP_LOAD_R, OP_FIN_R, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END
  } act_op_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
  } act_in_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    logic [15:0] data;
  } act_cfg_t;

  typedef struct packed {
    act_op_e    op;
    logic [4:0] idx;
  } act_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       short_vec;
    logic       capturing;
    logic       count_nz;
  } act_sts_t;

  // round(atan(2^-i) in degrees * 32768)
  function automatic logic [20:0] atan_ent(input logic [4:0] i);
    logic [20:0] v;
    case (i)
      5'd0:  v = 21'd1474560;
      5'd1:  v = 21'd870484;
      5'd2:  v = 21'd459940;
      5'd3:  v = 21'd233473;
      5'd4:  v = 21'd117189;
      5'd5:  v = 21'd58652;
      5'd6:  v = 21'd29333;
      5'd7:  v = 21'd14667;
      5'd8:  v = 21'd7334;
      5'd9:  v = 21'd3667;
      5'd10: v = 21'd1833;
      5'd11: v = 21'd917;
      5'd12: v = 21'd458;
      5'd13: v = 21'd229;
      5'd14: v = 21'd115;
      5'd15: v = 21'd57;
      5'd16: v = 21'd29;
      5'd17: v = 21'd14;
      5'd18: v = 21'd7;
      5'd19: v = 21'd4;
      5'd20: v = 21'd2;
      5'd21: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/act_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated tilt channels
// Input sample, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface act_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;
  modport source (output valid, kind, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, kind, sample_x, sample_y, sample_z, output ready);
endinterface

interface act_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [17:0] corrected_x;
  logic signed [17:0] corrected_y;
  logic signed [17:0] corrected_z;
  logic signed [14:0] pitch;
  logic signed [15:0] roll;
  logic [10:0]        samples_taken;
  modport source (output valid, status, corrected_x, corrected_y, corrected_z, pitch,
                  roll, samples_taken, input ready);
  modport sink   (input valid, status, corrected_x, corrected_y, corrected_z, pitch,
                  roll, samples_taken, output ready);
endinterface

interface act_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/act_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated tilt controller
// Sequences the datapath through correction, root, CORDIC and divide steps.
// ----------------------------------------------------------------------------
module act_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  act_pkg::act_sts_t sts_i,
  output act_pkg::act_cmd_t cmd_o
);
  import act_pkg::*;

  act_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] ax_q, ax_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ax_q    <= ax_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ax_d    = ax_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        cnt_d = '0;
        ax_d  = '0;
        if (sts_i.kind == KIND_MEASURE) begin
          state_d = S_MUL;
        end else if (sts_i.kind == KIND_CAL_END && sts_i.capturing && sts_i.count_nz) begin
          state_d = S_DIV_INIT;
        end else begin
          state_d = S_CAL;
        end
      end
      S_CAL: state_d = S_DONE;
      S_MUL: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(MUL_STEPS)) begin
          cnt_d   = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: state_d = sts_i.short_vec ? S_DONE : S_SQRT;
      S_SQRT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(SQRT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_LOAD_P;
        end
      end
      S_LOAD_P: state_d = S_CORD_P;
      S_CORD_P: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_ITERATIONS - 1)) begin
          cnt_d   = '0;
          state_d = S_LOAD_R;
        end
      end
      S_LOAD_R: state_d = S_CORD_R;
      S_CORD_R: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_ITERATIONS - 1)) begin
          cnt_d   = '0;
          state_d = S_FIN_R;
        end
      end
      S_FIN_R: state_d = S_DONE;
      S_DIV_INIT: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_STEPS - 1)) state_d = S_DIV_END;
      end
      S_DIV_END: begin
        if (ax_q == 2'd2) begin
          state_d = S_DONE;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_DIV_INIT;
        end
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = cnt_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_CAL:   cmd_o.op = OP_CAL;
      S_MUL: begin
        // The last count only lets the final product settle.
        if (cnt_q != 5'(MUL_STEPS)) cmd_o.op = OP_MUL;
      end
      S_CHECK:  cmd_o.op = OP_CHECK;
      S_SQRT:   cmd_o.op = OP_SQRT_STEP;
      S_LOAD_P: cmd_o.op = OP_LOAD_P;
      S_CORD_P: cmd_o.op = OP_CORD_STEP;
      S_LOAD_R: cmd_o.op = OP_LOAD_R;
      S_CORD_R: cmd_o.op = OP_CORD_STEP;
      S_FIN_R:  cmd_o.op = OP_FIN_R;
      S_DIV_INIT: begin
        cmd_o.op  = OP_DIV_INIT;
        cmd_o.idx = {3'b0, ax_q};
      end
      S_DIV:    cmd_o.op = OP_DIV_STEP;
      S_DIV_END: begin
        cmd_o.op  = OP_DIV_END;
        cmd_o.idx = {3'b0, ax_q};
      end
      S_DONE:   out_valid_o = 1'b1;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/act_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated tilt datapath
// Correction multiplier, square root, CORDIC, divider and calibration state.
// ----------------------------------------------------------------------------
module act_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  act_pkg::act_in_t  in_i,
  input  act_pkg::act_cfg_t cfg_i,
  input  act_pkg::act_cmd_t cmd_i,
  output act_pkg::act_sts_t sts_o,
  output logic [1:0]        status_o,
  output logic signed [17:0] cx_o,
  output logic signed [17:0] cy_o,
  output logic signed [17:0] cz_o,
  output logic signed [14:0] pitch_o,
  output logic signed [15:0] roll_o,
  output logic [10:0]       count_o
);
  import act_pkg::*;

  // Configuration and calibration state
  logic [15:0] gain_x_q, gain_y_q, gain_z_q;
  logic [14:0] grav_q, mn_q;
  logic        capturing_q;
  logic signed [26:0] sum_x_q, sum_y_q, sum_z_q;
  logic [CNT_W-1:0]   count_q;
  logic signed [17:0] off_x_q, off_y_q, off_z_q;

  // Item payload and working registers
  logic [1:0]         kind_q;
  logic signed [15:0] sx_q, sy_q, sz_q;
  logic signed [17:0] cx_q, cy_q, cz_q;
  logic signed [37:0] prod_q;
  logic               pv_q;
  logic [2:0]         psel_q;
  logic [35:0]        sqx_q, syz_q;
  logic [29:0]        mn2_q;
  logic [35:0]        rt_s_q, rt_r_q;
  logic signed [21:0] cr_x_q, cr_y_q;
  logic signed [24:0] cr_z_q;
  logic               cr_zero_q;
  logic [27:0]        dv_u_q;
  logic [11:0]        dv_r_q;
  logic               dv_neg_q;
  logic [1:0]         res_st_q;
  logic signed [17:0] res_cx_q, res_cy_q, res_cz_q;
  logic signed [14:0] res_p_q;
  logic signed [15:0] res_r_q;

  function automatic logic signed [17:0] sat18(input logic signed [37:0] p);
    logic signed [37:0] rnd;
    logic signed [23:0] sh;
    logic signed [17:0] r;
    rnd = p + 38'sd8192;
    sh  = rnd[37:14];
    if (sh > 24'sd131071)       r = 18'sh1FFFF;
    else if (sh < -24'sd131072) r = 18'sh20000;
    else                        r = sh[17:0];
    return r;
  endfunction

  function automatic logic signed [16:0] fin_ang(input logic signed [24:0] z,
                                                 input logic signed [16:0] lim);
    logic signed [24:0] zr;
    logic signed [16:0] a;
    logic signed [16:0] r;
    zr = z + 25'sd128;
    a  = zr[24:8];
    if (a > lim)       r = lim;
    else if (a < -lim) r = -lim;
    else               r = a;
    return r;
  endfunction

  // Shared multiplier operand selection
  logic signed [18:0] ma, mb;
  logic signed [37:0] prod_d;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.idx[2:0])
      3'd0: begin ma = 19'(sx_q) - 19'(off_x_q); mb = signed'({3'b0, gain_x_q}); end
      3'd1: begin ma = 19'(sy_q) - 19'(off_y_q); mb = signed'({3'b0, gain_y_q}); end
      3'd2: begin ma = 19'(sz_q) - 19'(off_z_q); mb = signed'({3'b0, gain_z_q}); end
      3'd3: begin ma = 19'(cx_q); mb = 19'(cx_q); end
      3'd4: begin ma = 19'(cy_q); mb = 19'(cy_q); end
      3'd5: begin ma = 19'(cz_q); mb = 19'(cz_q); end
      3'd6: begin ma = signed'({4'b0, mn_q}); mb = signed'({4'b0, mn_q}); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod_d = ma * mb;
  end

  // Small-vector test
  logic [36:0] norm2;
  logic        short_vec;
  assign norm2     = {1'b0, sqx_q} + {1'b0, syz_q};
  assign short_vec = norm2 < {7'b0, mn2_q};

  // Square root step
  logic [5:0]  rt_sh;
  logic [35:0] rt_bit;
  logic [36:0] rt_trial;
  assign rt_sh    = 6'd34 - {cmd_i.idx, 1'b0};
  assign rt_bit   = 36'd1 << rt_sh;
  assign rt_trial = {1'b0, rt_r_q} + {1'b0, rt_bit};

  // CORDIC operand loading with left half plane pre-rotation
  logic signed [21:0] ld_x, ld_y, ld_xo, ld_yo;
  logic signed [24:0] ld_z;
  always_comb begin
    if (cmd_i.op == OP_LOAD_P) begin
      ld_y = -(22'(cx_q));
      ld_x = signed'({4'b0, rt_r_q[17:0]});
    end else begin
      ld_y = 22'(cy_q);
      ld_x = 22'(cz_q);
    end
    ld_xo = ld_x;
    ld_yo = ld_y;
    ld_z  = '0;
    if (ld_x < 0) begin
      if (ld_y >= 0) begin
        ld_xo = ld_y;
        ld_yo = -ld_x;
        ld_z  = 25'sd2949120;
      end else begin
        ld_xo = -ld_y;
        ld_yo = ld_x;
        ld_z  = -25'sd2949120;
      end
    end
  end

  logic signed [21:0] cr_xs, cr_ys;
  logic signed [24:0] cr_a;
  assign cr_xs = cr_x_q >>> cmd_i.idx;
  assign cr_ys = cr_y_q >>> cmd_i.idx;
  assign cr_a  = signed'({4'b0, atan_ent(cmd_i.idx)});

  logic signed [16:0] ang_p, ang_r;
  assign ang_p = fin_ang(cr_z_q, 17'sd11520);
  assign ang_r = fin_ang(cr_z_q, 17'sd23040);

  // Divider set-up: floor((2*sum + n) / (2*n)) via the magnitude of the numerator
  logic signed [26:0] dv_sum;
  logic signed [28:0] dv_num;
  logic [11:0]        dv_den;
  logic [12:0]        dv_rsh;
  logic               dv_qb;
  logic [27:0]        dv_q;
  logic signed [17:0] dv_avg;
  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    dv_sum = sum_x_q;
      2'd1:    dv_sum = sum_y_q;
      default: dv_sum = sum_z_q;
    endcase
    dv_num = (29'(dv_sum) <<< 1) + signed'({18'b0, count_q});
    dv_den = {count_q, 1'b0};
    dv_rsh = {dv_r_q, dv_u_q[27]};
    dv_qb  = dv_rsh >= {1'b0, dv_den};
    dv_q   = dv_neg_q ? ~dv_u_q : dv_u_q;
    dv_avg = dv_q[17:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_x_q    <= 16'd16384;
      gain_y_q    <= 16'd16384;
      gain_z_q    <= 16'd16384;
      grav_q      <= 15'd16384;
      mn_q        <= 15'd167;
      capturing_q <= 1'b0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_z_q     <= '0;
      count_q     <= '0;
      off_x_q     <= '0;
      off_y_q     <= '0;
      off_z_q     <= '0;
      pv_q        <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.index)
          REG_GAIN_X:   gain_x_q <= cfg_i.data;
          REG_GAIN_Y:   gain_y_q <= cfg_i.data;
          REG_GAIN_Z:   gain_z_q <= cfg_i.data;
          REG_GRAVITY:  grav_q   <= cfg_i.data[14:0];
          REG_MIN_NORM: mn_q     <= cfg_i.data[14:0];
          default: ;
        endcase
      end
      pv_q <= (cmd_i.op == OP_MUL);
      if (cmd_i.op == OP_CAL) begin
        case (kind_q)
          KIND_CAL_START: begin
            capturing_q <= 1'b1;
            sum_x_q     <= '0;
            sum_y_q     <= '0;
            sum_z_q     <= '0;
            count_q     <= '0;
          end
          KIND_CAL_ADD: begin
            if (capturing_q && count_q < CNT_W'(MAX_CAL_SAMPLES)) begin
              sum_x_q <= sum_x_q + 27'(sx_q);
              sum_y_q <= sum_y_q + 27'(sy_q);
              sum_z_q <= sum_z_q + 27'(sz_q);
              count_q <= count_q + CNT_W'(1);
            end
          end
          KIND_CAL_END: capturing_q <= 1'b0;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_DIV_END) begin
        case (cmd_i.idx[1:0])
          2'd0: off_x_q <= dv_avg;
          2'd1: off_y_q <= dv_avg;
          default: begin
            off_z_q     <= dv_avg - signed'({3'b0, grav_q});
            capturing_q <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      kind_q <= in_i.kind;
      sx_q   <= in_i.sample_x;
      sy_q   <= in_i.sample_y;
      sz_q   <= in_i.sample_z;
    end
    if (cmd_i.op == OP_MUL) begin
      prod_q <= prod_d;
      psel_q <= cmd_i.idx[2:0];
    end
    // Products are registered in prod_q and land in their destination in the cycle after.
    if (pv_q) begin
      case (psel_q)
        3'd0: cx_q  <= sat18(prod_q);
        3'd1: cy_q  <= sat18(prod_q);
        3'd2: cz_q  <= sat18(prod_q);
        3'd3: sqx_q <= prod_q[35:0];
        3'd4: syz_q <= prod_q[35:0];
        3'd5: syz_q <= syz_q + prod_q[35:0];
        3'd6: mn2_q <= prod_q[29:0];
        default: ;
      endcase
    end
    case (cmd_i.op)
      OP_CAL: begin
        res_cx_q <= '0;
        res_cy_q <= '0;
        res_cz_q <= '0;
        res_p_q  <= '0;
        res_r_q  <= '0;
        case (kind_q)
          KIND_CAL_ADD: res_st_q <= (capturing_q && count_q < CNT_W'(MAX_CAL_SAMPLES)) ?
                                    ST_ACK : ST_IGNORED;
          KIND_CAL_END: res_st_q <= capturing_q ? ST_ACK : ST_IGNORED;
          default:      res_st_q <= ST_ACK;
        endcase
      end
      OP_CHECK: begin
        rt_s_q   <= syz_q;
        rt_r_q   <= '0;
        res_st_q <= ST_UNDEF;
        res_cx_q <= cx_q;
        res_cy_q <= cy_q;
        res_cz_q <= cz_q;
        res_p_q  <= '0;
        res_r_q  <= '0;
      end
      OP_SQRT_STEP: begin
        if ({1'b0, rt_s_q} >= rt_trial) begin
          rt_s_q <= rt_s_q - rt_trial[35:0];
          rt_r_q <= (rt_r_q >> 1) + rt_bit;
        end else begin
          rt_r_q <= rt_r_q >> 1;
        end
      end
      OP_LOAD_P, OP_LOAD_R: begin
        if (cmd_i.op == OP_LOAD_R) res_p_q <= cr_zero_q ? 15'sd0 : ang_p[14:0];
        cr_x_q    <= ld_xo;
        cr_y_q    <= ld_yo;
        cr_z_q    <= ld_z;
        cr_zero_q <= (ld_x == 0) && (ld_y == 0);
      end
      OP_CORD_STEP: begin
        if (!cr_y_q[21]) begin
          cr_x_q <= cr_x_q + cr_ys;
          cr_y_q <= cr_y_q - cr_xs;
          cr_z_q <= cr_z_q + cr_a;
        end else begin
          cr_x_q <= cr_x_q - cr_ys;
          cr_y_q <= cr_y_q + cr_xs;
          cr_z_q <= cr_z_q - cr_a;
        end
      end
      OP_FIN_R: begin
        res_r_q  <= cr_zero_q ? 16'sd0 : ang_r[15:0];
        res_st_q <= ST_OK;
      end
      OP_DIV_INIT: begin
        dv_neg_q <= dv_num[28];
        dv_u_q   <= dv_num[28] ? ~dv_num[27:0] : dv_num[27:0];
        dv_r_q   <= '0;
      end
      OP_DIV_STEP: begin
        dv_u_q <= {dv_u_q[26:0], dv_qb};
        dv_r_q <= dv_qb ? 12'(dv_rsh - {1'b0, dv_den}) : dv_rsh[11:0];
      end
      OP_DIV_END: begin
        res_st_q <= ST_ACK;
        res_cx_q <= '0;
        res_cy_q <= '0;
        res_cz_q <= '0;
        res_p_q  <= '0;
        res_r_q  <= '0;
      end
      default: ;
    endcase
  end

  assign sts_o.kind      = kind_q;
  assign sts_o.short_vec = short_vec;
  assign sts_o.capturing = capturing_q;
  assign sts_o.count_nz  = (count_q != '0);

  assign status_o = res_st_q;
  assign cx_o     = res_cx_q;
  assign cy_o     = res_cy_q;
  assign cz_o     = res_cz_q;
  assign pitch_o  = res_p_q;
  assign roll_o   = res_r_q;
  assign count_o  = 11'(count_q);

endmodule

>>> rtl/accel_calibrated_tilt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated accelerometer tilt core
// Offset and gain correction, pitch and roll by CORDIC, offset calibration.
// ----------------------------------------------------------------------------
// A measure item runs correction, then, unless the vector is too short, the
// square root (18 steps) and two 16-step CORDIC passes, one after another.
// Start, sample and empty finish items only update the calibration state; a
// finish with samples runs three 28-step serial divides.
// One item is in flight; the next is taken in the cycle after the result leaves.
// Reset restores register defaults, clears the capture and zeroes the offsets.
module accel_calibrated_tilt_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  act_in_if.sink     in_i,
  act_out_if.source  out_o,
  act_cfg_if.sink    cfg_i
);
  import act_pkg::*;

  act_in_t  in_d;
  act_cfg_t cfg_d;
  act_cmd_t cmd;
  act_sts_t sts;

  assign in_d.kind     = in_i.kind;
  assign in_d.sample_x = in_i.sample_x;
  assign in_d.sample_y = in_i.sample_y;
  assign in_d.sample_z = in_i.sample_z;

  assign cfg_i.ready = 1'b1;
  assign cfg_d.we    = cfg_i.valid;
  assign cfg_d.index = cfg_i.index;
  assign cfg_d.data  = cfg_i.data;

  act_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  act_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_d),
    .cfg_i    (cfg_d),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .status_o (out_o.status),
    .cx_o     (out_o.corrected_x),
    .cy_o     (out_o.corrected_y),
    .cz_o     (out_o.corrected_z),
    .pitch_o  (out_o.pitch),
    .roll_o   (out_o.roll),
    .count_o  (out_o.samples_taken)
  );

endmodule
